[design/kda_pkg.sv]
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types, widths and codes for the keypad debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package kda_pkg;

    localparam int KEY_COUNT_DEF = 6;    // default number of key lanes
    localparam int LEVEL_W       = 6;    // key_levels field width
    localparam int CNT_W         = 8;    // per-key hold counter width
    localparam int PCNT_W        = 16;   // power hold counter width
    localparam int CODE_W        = 3;    // key_code field width
    localparam int KIND_W        = 2;    // kind field width
    localparam int PKEY_W        = 3;    // power_key register width
    localparam int CFG_IDX_W     = 3;    // configuration register index width
    localparam int CFG_DATA_W    = 16;   // configuration write data width
    localparam int IN_TDATA_W    = 8;
    localparam int IN_TUSER_W    = 3;
    localparam int OUT_TDATA_W   = 8;
    localparam int NUM_POWER_KEYS = 6;   // highest valid power key number

    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN = 2'd0,
        KIND_TAKE = 2'd1,
        KIND_PEEK = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_THRESHOLD   = 3'd0,
        REG_RELEASE_THRESHOLD = 3'd1,
        REG_RELEASE_CLAMP     = 3'd2,
        REG_REPEAT_DELAY      = 3'd3,
        REG_REPEAT_STEP       = 3'd4,
        REG_POWER_HOLD_LIMIT  = 3'd5,
        REG_REPEAT_KEY_MASK   = 3'd6,
        REG_POWER_KEY         = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]   press_threshold;
        logic [CNT_W-1:0]   release_threshold;
        logic [CNT_W-1:0]   release_clamp;
        logic [CNT_W-1:0]   repeat_delay;
        logic [CNT_W-1:0]   repeat_step;
        logic [PCNT_W-1:0]  power_hold_limit;
        logic [LEVEL_W-1:0] repeat_key_mask;
        logic [PKEY_W-1:0]  power_key;
    } cfg_t;

    // Per-lane control for the item being accepted this cycle.
    typedef struct packed {
        logic scan;        // scan item accepted
        logic down;        // this key's level
        logic repeats;     // this key auto-repeats
        logic flush;       // take or peek with slept set
        logic take_clear;  // this key is the one being taken
    } lane_ctrl_t;

    // Per-lane findings handed to the merge stage.
    typedef struct packed {
        logic pending;     // registered event flag
        logic wake;        // newly debounced to pressed on this scan
        logic long_hold;   // held at or past the delay without repeating
    } lane_stat_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              wake;
        logic              power_off;
    } result_t;

endpackage

[design/kda_lane.sv]
// ----------------------------------------------------------------------------
// kda_lane
// One key: hold counter, debounced status and sticky event flag.
// ----------------------------------------------------------------------------
module kda_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  kda_pkg::cfg_t       cfg,
    input  kda_pkg::lane_ctrl_t ctrl,
    output kda_pkg::lane_stat_t stat
);
    import kda_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             status_reg;
    logic             status_next;
    logic             pending_reg;
    logic             pending_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_clamped;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_reload;
    logic             wake;
    logic             long_hold;

    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign cnt_clamped = (cnt_reg > cfg.release_clamp) ? cfg.release_clamp : cnt_reg;
    assign cnt_dec     = (cnt_clamped != '0) ? cnt_clamped - CNT_W'(1) : '0;
    assign cnt_reload  = (cfg.repeat_step > cfg.repeat_delay) ? '0
                         : cfg.repeat_delay - cfg.repeat_step;

    always_comb
    begin
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        pending_next = pending_reg;
        wake         = 1'b0;
        long_hold    = 1'b0;
        if (ctrl.flush)
        begin
            cnt_next     = '0;
            status_next  = 1'b0;
            pending_next = 1'b0;
        end
        else if (ctrl.scan)
        begin
            if (ctrl.down)
            begin
                if (cnt_reg < cfg.repeat_delay)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc > cfg.press_threshold && !status_reg)
                    begin
                        pending_next = 1'b1;
                        status_next  = 1'b1;
                        wake         = 1'b1;
                    end
                end
                else if (ctrl.repeats)
                begin
                    pending_next = 1'b1;
                    status_next  = 1'b1;
                    cnt_next     = cnt_reload;
                end
                else
                begin
                    long_hold = 1'b1;
                end
            end
            else if (cnt_reg != '0)
            begin
                pending_next = 1'b0;
                cnt_next     = cnt_dec;
                if (cnt_dec < cfg.release_threshold)
                begin
                    status_next = 1'b0;
                end
            end
        end
        else if (ctrl.take_clear)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            status_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            status_reg  <= status_next;
            pending_reg <= pending_next;
        end
    end

    assign stat.pending   = pending_reg;
    assign stat.wake      = wake;
    assign stat.long_hold = long_hold;

endmodule

[design/kda_merge.sv]
// ----------------------------------------------------------------------------
// kda_merge
// Combines the lanes: lowest pending key, wake, and the power hold counter.
// ----------------------------------------------------------------------------
module kda_merge #(
    parameter int KEY_COUNT = kda_pkg::KEY_COUNT_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  kda_pkg::kind_t                          kind,
    input  logic                                    slept,
    input  logic [KEY_COUNT-1:0]                    levels,
    input  kda_pkg::lane_stat_t [KEY_COUNT-1:0]     stat,
    input  logic [kda_pkg::PCNT_W-1:0]              power_hold_limit,
    input  logic [kda_pkg::PKEY_W-1:0]              power_key,
    output logic [KEY_COUNT-1:0]                    grant,
    output kda_pkg::result_t                        result
);
    import kda_pkg::*;

    logic [PCNT_W-1:0]  pcount_reg;
    logic [PCNT_W-1:0]  pcount_next;
    logic [PCNT_W-1:0]  pcount_inc;
    logic [CODE_W-1:0]  low_code;
    logic [KEY_COUNT-1:0] is_power;
    logic               any_wake;
    logic               power_up;
    logic               power_long;
    logic               found;

    function automatic logic [KEY_COUNT-1:0] long_vec(
        input lane_stat_t [KEY_COUNT-1:0] s
    );
        logic [KEY_COUNT-1:0] v;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            v[k] = s[k].long_hold;
        end
        return v;
    endfunction

    // Lowest pending key wins; key numbers are masked to the code width.
    always_comb
    begin
        grant    = '0;
        low_code = '0;
        found    = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (stat[k].pending && !found)
            begin
                found    = 1'b1;
                grant[k] = 1'b1;
                low_code = CODE_W'(k + 1);
            end
        end
    end

    always_comb
    begin
        any_wake = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            is_power[k] = (power_key != '0)
                          && (int'(power_key) <= NUM_POWER_KEYS)
                          && (int'(power_key) == k + 1);
            any_wake    = any_wake | stat[k].wake;
        end
    end

    assign power_up   = |(is_power & ~levels);
    assign power_long = |(is_power & levels) && |(is_power & long_vec(stat));
    assign pcount_inc = (pcount_reg == {PCNT_W{1'b1}}) ? pcount_reg
                        : pcount_reg + PCNT_W'(1);

    always_comb
    begin
        pcount_next = pcount_reg;
        result      = '0;
        unique case (kind)
            KIND_SCAN:
            begin
                result.wake = any_wake;
                if (power_up)
                begin
                    pcount_next = '0;
                end
                else if (power_long)
                begin
                    pcount_next      = pcount_inc;
                    result.power_off = pcount_inc > power_hold_limit;
                end
            end
            KIND_TAKE, KIND_PEEK:
            begin
                result.key_code = slept ? '0 : low_code;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
        end
        else if (accept)
        begin
            pcount_reg <= pcount_next;
        end
    end

    // Power off is only reported once the saturating count has passed the limit.
    a_poff_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.power_off |=> pcount_reg > power_hold_limit)
        else $error("power_off without hold count past limit");

    // A release of the power key on a scan empties the hold count.
    a_power_release: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == KIND_SCAN && power_up |=> pcount_reg == '0)
        else $error("power hold count not cleared on release");

    // Only one lane can be granted.
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant))
        else $error("more than one key granted");

endmodule

[design/keypad_debounce_autorepeat.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat
// Multi-key debouncer with sticky press events, auto-repeat and power hold.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, back to back, while its output is
// not stalled, and returns exactly one result item for each, in the cycle
// after acceptance, from an output register. A scan item (kind 0) carries the
// level of every key in tdata; each key has its own lane that updates its hold
// counter, debounced status and event flag in the same cycle, and the merge
// stage ORs the wake pulses and keeps the saturating power hold count. A take
// item (kind 1) returns and clears the lowest key with a pending event, a peek
// item (kind 2) returns it and leaves it pending; with slept set either one
// first clears every key's state, so it returns zero. Kind 3 changes nothing
// and returns zeros. Each result comes from the lane update and the priority
// encode of the pending flags, and the input stays ready whenever the output
// register is empty or being drained. Configuration writes are taken in any
// cycle and must only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module keypad_debounce_autorepeat #(
    parameter int KEY_COUNT = kda_pkg::KEY_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [kda_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [5:0] key_levels
    input  logic [kda_pkg::IN_TUSER_W-1:0]     s_axis_tuser,   // [1:0] kind, [2] slept
    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [kda_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [2:0] key_code, [3] wake,
                                                               // [4] power_off
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kda_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kda_pkg::*;

    cfg_t                         cfg_reg;
    cfg_t                         cfg_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    result_t                      out_data_reg;

    logic                         accept;
    kind_t                        kind;
    logic                         slept;
    logic [KEY_COUNT-1:0]         levels;
    logic [KEY_COUNT-1:0]         repeats;
    logic [KEY_COUNT-1:0]         grant;
    logic [KEY_COUNT-1:0]         pending_vec;
    lane_ctrl_t [KEY_COUNT-1:0]   lane_ctrl;
    lane_stat_t [KEY_COUNT-1:0]   lane_stat;
    result_t                      result;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = kind_t'(s_axis_tuser[KIND_W-1:0]);
    assign slept         = s_axis_tuser[KIND_W];

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PRESS_THRESHOLD:   cfg_next.press_threshold   = cfg_data[CNT_W-1:0];
                REG_RELEASE_THRESHOLD: cfg_next.release_threshold = cfg_data[CNT_W-1:0];
                REG_RELEASE_CLAMP:     cfg_next.release_clamp     = cfg_data[CNT_W-1:0];
                REG_REPEAT_DELAY:      cfg_next.repeat_delay      = cfg_data[CNT_W-1:0];
                REG_REPEAT_STEP:       cfg_next.repeat_step       = cfg_data[CNT_W-1:0];
                REG_POWER_HOLD_LIMIT:  cfg_next.power_hold_limit  = cfg_data[PCNT_W-1:0];
                REG_REPEAT_KEY_MASK:   cfg_next.repeat_key_mask   = cfg_data[LEVEL_W-1:0];
                REG_POWER_KEY:         cfg_next.power_key         = cfg_data[PKEY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_threshold   <= CNT_W'(3);
            cfg_reg.release_threshold <= CNT_W'(2);
            cfg_reg.release_clamp     <= CNT_W'(5);
            cfg_reg.repeat_delay      <= CNT_W'(100);
            cfg_reg.repeat_step       <= CNT_W'(10);
            cfg_reg.power_hold_limit  <= PCNT_W'(50);
            cfg_reg.repeat_key_mask   <= LEVEL_W'(12);
            cfg_reg.power_key         <= PKEY_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Key lanes. Keys beyond the level field never read as held down.
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        if (k < LEVEL_W)
        begin : g_wired
            assign levels[k]  = s_axis_tdata[k];
            assign repeats[k] = cfg_reg.repeat_key_mask[k];
        end
        else
        begin : g_unwired
            assign levels[k]  = 1'b0;
            assign repeats[k] = 1'b0;
        end

        assign lane_ctrl[k].scan       = accept && kind == KIND_SCAN;
        assign lane_ctrl[k].down       = levels[k];
        assign lane_ctrl[k].repeats    = repeats[k];
        assign lane_ctrl[k].flush      = accept && slept
                                         && (kind == KIND_TAKE || kind == KIND_PEEK);
        assign lane_ctrl[k].take_clear = accept && kind == KIND_TAKE && grant[k];
        assign pending_vec[k]          = lane_stat[k].pending;

        kda_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .cfg   (cfg_reg),
            .ctrl  (lane_ctrl[k]),
            .stat  (lane_stat[k])
        );
    end

    kda_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .kind             (kind),
        .slept            (slept),
        .levels           (levels),
        .stat             (lane_stat),
        .power_hold_limit (cfg_reg.power_hold_limit),
        .power_key        (cfg_reg.power_key),
        .grant            (grant),
        .result           (result)
    );

    // Output register: holds a finished result while the next item is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - CODE_W - 2){1'b0}},
                            out_data_reg.power_off, out_data_reg.wake,
                            out_data_reg.key_code};

    // A take or peek item never reports wake or power off.
    a_take_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind != KIND_SCAN |=> !out_data_reg.wake && !out_data_reg.power_off)
        else $error("wake or power_off on a non-scan item");

    // A scan item never returns a key code.
    a_scan_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == KIND_SCAN |=> out_data_reg.key_code == '0)
        else $error("key code on a scan item");

    // A sleep flush leaves no key event pending.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && slept && (kind == KIND_TAKE || kind == KIND_PEEK)
        |=> pending_vec == '0)
        else $error("pending events survive a sleep flush");

    // A stalled result is never overwritten by a new item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !accept)
        else $error("item accepted over a stalled result");

endmodule
